### hdl/brle_pkg.sv
// Shared types and constants for the block run-length encoder.
// Command and status bundles between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brle_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 5;

    localparam logic [BYTE_W-1:0] COUNT_LIMIT = 8'd255;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // input transfer: write incoming byte, read run byte
        logic decide;      // compare result is in, update run state and plan output
        logic cnt_load;    // load count byte of current group into output register
        logic rd_issue;    // read next block byte of current group
        logic dat_load;    // load block byte into output register
        logic next_group;  // switch to second pending group
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic plan_any;    // decide step produced at least one group
        logic out_free;    // output register can take a byte this cycle
        logic byte_last;   // current block byte is the last of its group
        logic grp2_vld;    // a second group waits after the current one
    } t_sts;

endpackage

`default_nettype wire

### hdl/block_run_length_encoder_core.sv
// Block run-length encoder, top level: controller plus datapath.
// Depends on brle_pkg, brle_ctrl, brle_dp (which holds brle_ram).
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one raw byte and a
//   stream_end flag per transfer. Output channel (o_out_valid / i_out_ready)
//   carries count bytes (o_is_count high) and block bytes; o_last_of_item
//   marks the final byte caused by one input, o_end_of_output the final byte
//   of a stream.
//   Block length is written through i_cfg_wr_en / i_cfg_wr_data while idle;
//   the write clamps it to 1..BLOCK_MAX and drops any pending run.
//   Timing: one byte at a time. A byte that emits nothing passes through the
//   transfer, then the compare against the run block read from the block RAM.
//   Each emitted group loads its count byte, then reads and loads each block
//   byte in turn, paced by the single registered read port of the block RAM;
//   the first output byte is the count byte, registered after the compare step.
//   A stalled receiver holds the output register and the emission sequence
//   waits; a new input is taken as soon as the last byte sits in the output
//   register. Reset empties the run state and sets block length to 1; the
//   block RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module block_run_length_encoder_core
    import brle_pkg::*;
#(
    parameter int BLOCK_MAX = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]  i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_stream_end,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic                   o_is_count,
    output logic                   o_last_of_item,
    output logic                   o_end_of_output
);

    t_cmd w_cmd;
    t_sts w_sts;

    brle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    brle_dp #(
        .BLOCK_MAX (BLOCK_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_data_byte     (i_data_byte),
        .i_stream_end    (i_stream_end),
        .i_out_ready     (i_out_ready),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_out_valid),
        .o_out_byte      (o_out_byte),
        .o_is_count      (o_is_count),
        .o_last_of_item  (o_last_of_item),
        .o_end_of_output (o_end_of_output)
    );

    // the compare step always follows a transfer
    a_busy_after_xfer : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (!o_in_ready && w_cmd.decide))
        else $error("input taken again right after a transfer");

    a_cmd_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.accept, w_cmd.decide, w_cmd.cnt_load, w_cmd.rd_issue,
                  w_cmd.dat_load}))
        else $error("controller issued overlapping commands");

    a_eoo_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_output) |-> (o_last_of_item && !o_is_count))
        else $error("end of output not on a final block byte");

    a_count_then_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.cnt_load |=> w_cmd.rd_issue)
        else $error("count byte not followed by a block read");

endmodule

`default_nettype wire

### hdl/brle_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module brle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hdl/brle_ctrl.sv
// Controller state machine for the block run-length encoder.
// Sequences input transfer, compare, and count/block byte emission.
// Depends on brle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brle_ctrl
    import brle_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_CNT  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_LD   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.plan_any ? S_CNT : S_IDLE;
            end
            S_CNT: begin
                if (i_sts.out_free) begin
                    o_cmd.cnt_load = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_LD;
            end
            S_LD: begin
                // hold read data until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.dat_load = 1'b1;
                    if (!i_sts.byte_last) begin
                        n_state = S_RD;
                    end else if (i_sts.grp2_vld) begin
                        o_cmd.next_group = 1'b1;
                        n_state          = S_CNT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### hdl/brle_dp.sv
// Datapath for the block run-length encoder: run state, two-bank block RAM,
// emission plan and output register. Depends on brle_pkg and brle_ram.
`timescale 1ns / 1ps
`default_nettype none

module brle_dp
    import brle_pkg::*;
#(
    parameter int BLOCK_MAX = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]  i_cfg_wr_data,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_stream_end,
    input  wire logic              i_out_ready,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    output logic                   o_out_valid,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic                   o_is_count,
    output logic                   o_last_of_item,
    output logic                   o_end_of_output
);

    localparam int IW    = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;
    localparam int LW    = $clog2(BLOCK_MAX + 1);
    localparam int DEPTH = 2 ** (IW + 1);

    // stream state
    logic [LW-1:0]     r_len;
    logic [IW-1:0]     r_fill;
    logic              r_run_vld;
    logic [BYTE_W-1:0] r_cnt;
    logic              r_match;
    logic              r_sel;      // bank holding the run block
    logic [BYTE_W-1:0] r_byte;
    logic              r_end;

    // emission plan
    logic [BYTE_W-1:0] r_g_cnt;
    logic              r_g_bank;
    logic [LW-1:0]     r_g_len;
    logic              r_g2_vld;
    logic              r_g2_bank;
    logic [LW-1:0]     r_g2_len;
    logic [IW-1:0]     r_idx;

    // output register
    logic              r_o_vld;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_cnt;
    logic              r_o_last;
    logic              r_o_eoo;

    logic [BYTE_W-1:0] w_rd_data;
    logic [IW:0]       w_wr_addr;
    logic [IW:0]       w_rd_addr;
    logic [CFG_W-1:0]  w_cfg_len;

    // decide step
    logic              w_mis;
    logic              w_match;
    logic [LW-1:0]     w_fill_inc;
    logic              w_full;
    logic [BYTE_W-1:0] w_cnt_inc;
    logic              w_a_vld;
    logic [BYTE_W-1:0] w_a_cnt;
    logic              w_b_vld;
    logic              w_b_bank;
    logic [LW-1:0]     w_b_len;
    logic              w_n_run_vld;
    logic [BYTE_W-1:0] w_n_cnt;
    logic              w_n_sel;
    logic [IW-1:0]     w_n_fill;
    logic              w_n_match;
    logic              w_last_out;

    assign w_wr_addr = {~r_sel, r_fill};
    assign w_rd_addr = i_cmd.accept ? {r_sel, r_fill} : {r_g_bank, r_idx};

    brle_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.accept),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_data_byte),
        .i_rd_en   (i_cmd.accept | i_cmd.rd_issue),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // clamp block length into 1..BLOCK_MAX
    always_comb begin
        w_cfg_len = i_cfg_wr_data;
        if (i_cfg_wr_data == '0) begin
            w_cfg_len = CFG_W'(1);
        end else if (i_cfg_wr_data > CFG_W'(BLOCK_MAX)) begin
            w_cfg_len = CFG_W'(BLOCK_MAX);
        end
    end

    assign w_mis      = r_run_vld && (w_rd_data != r_byte);
    assign w_match    = r_match && !w_mis;
    assign w_fill_inc = LW'(r_fill) + LW'(1);
    assign w_full     = (w_fill_inc == r_len);
    assign w_cnt_inc  = r_cnt + 8'd1;

    always_comb begin
        w_a_vld     = 1'b0;
        w_a_cnt     = r_cnt;
        w_b_vld     = 1'b0;
        w_b_bank    = ~r_sel;
        w_b_len     = r_len;
        w_n_run_vld = r_run_vld;
        w_n_cnt     = r_cnt;
        w_n_sel     = r_sel;
        w_n_fill    = w_fill_inc[IW-1:0];
        w_n_match   = w_match;
        if (w_full) begin
            w_n_fill  = '0;
            w_n_match = 1'b1;
            if (r_run_vld && w_match) begin
                // block repeats the run: count it, close at the limit or at stream end
                w_a_vld = (w_cnt_inc == COUNT_LIMIT) || r_end;
                w_a_cnt = w_cnt_inc;
                if (w_cnt_inc == COUNT_LIMIT) begin
                    w_n_run_vld = 1'b0;
                    w_n_cnt     = '0;
                end else begin
                    w_n_cnt = w_cnt_inc;
                end
            end else begin
                // close old run, incoming bank becomes the run bank; at stream end it is emitted too
                w_a_vld     = r_run_vld;
                w_b_vld     = r_end;
                w_n_sel     = ~r_sel;
                w_n_run_vld = 1'b1;
                w_n_cnt     = 8'd1;
            end
        end else begin
            w_a_vld = r_end && r_run_vld;
            w_b_vld = r_end;
            w_b_len = w_fill_inc;
        end
        if (r_end) begin
            w_n_run_vld = 1'b0;
            w_n_cnt     = '0;
            w_n_fill    = '0;
            w_n_match   = 1'b1;
        end
    end

    assign w_last_out = o_sts.byte_last && !r_g2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LW'(1);
            r_fill    <= '0;
            r_run_vld <= 1'b0;
            r_cnt     <= '0;
            r_match   <= 1'b1;
            r_sel     <= 1'b0;
            r_g2_vld  <= 1'b0;
            r_o_vld   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_len     <= w_cfg_len[LW-1:0];
                r_fill    <= '0;
                r_run_vld <= 1'b0;
                r_cnt     <= '0;
                r_match   <= 1'b1;
            end else if (i_cmd.decide) begin
                r_fill    <= w_n_fill;
                r_run_vld <= w_n_run_vld;
                r_cnt     <= w_n_cnt;
                r_match   <= w_n_match;
                r_sel     <= w_n_sel;
            end
            if (i_cmd.decide) begin
                r_g2_vld <= w_a_vld && w_b_vld;
            end else if (i_cmd.next_group) begin
                r_g2_vld <= 1'b0;
            end
            if (i_cmd.cnt_load || i_cmd.dat_load) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_data_byte;
            r_end  <= i_stream_end;
        end
        if (i_cmd.decide) begin
            r_g_cnt   <= w_a_vld ? w_a_cnt : 8'd1;
            r_g_bank  <= w_a_vld ? r_sel : w_b_bank;
            r_g_len   <= w_a_vld ? r_len : w_b_len;
            r_g2_bank <= w_b_bank;
            r_g2_len  <= w_b_len;
            r_idx     <= '0;
        end else if (i_cmd.next_group) begin
            r_g_cnt  <= 8'd1;
            r_g_bank <= r_g2_bank;
            r_g_len  <= r_g2_len;
            r_idx    <= '0;
        end else if (i_cmd.dat_load) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.cnt_load) begin
            r_o_byte <= r_g_cnt;
            r_o_cnt  <= 1'b1;
            r_o_last <= 1'b0;
            r_o_eoo  <= 1'b0;
        end else if (i_cmd.dat_load) begin
            r_o_byte <= w_rd_data;
            r_o_cnt  <= 1'b0;
            r_o_last <= w_last_out;
            r_o_eoo  <= w_last_out && r_end;
        end
    end

    assign o_sts.plan_any  = w_a_vld || w_b_vld;
    assign o_sts.out_free  = !r_o_vld || i_out_ready;
    assign o_sts.byte_last = ((LW'(r_idx) + LW'(1)) == r_g_len);
    assign o_sts.grp2_vld  = r_g2_vld;

    assign o_out_valid     = r_o_vld;
    assign o_out_byte      = r_o_byte;
    assign o_is_count      = r_o_cnt;
    assign o_last_of_item  = r_o_last;
    assign o_end_of_output = r_o_eoo;

endmodule

`default_nettype wire
